/* sv/assert_macros.svh */
// Assertion macros for the RTL files (included by the back end).
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
// Clocked property, disabled while reset is asserted (active low).
`define LBP_ASSERT(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (prop)) \
    else $error("assertion failed");
// Clocked property that also holds during reset.
`define LBP_ASSERT_ALWAYS(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) (prop)) \
    else $error("assertion failed");
`else
`define LBP_ASSERT(lbl, clk, rstn, prop)
`define LBP_ASSERT_ALWAYS(lbl, clk, prop)
`endif
`endif

/* sv/lbp_pkg.sv */
// Package: item types, back-end states and constants of the bit packer.
`timescale 1ns / 1ps
package lbp_pkg;

  localparam int BYTE_BITS   = 8;
  localparam int QUEUE_DEPTH = 2;

  localparam logic MODE_WRITE = 1'b0;
  localparam logic MODE_FLUSH = 1'b1;

  typedef logic [3:0] held_t;

  typedef struct packed {
    logic        mode;
    logic [63:0] code_value;
    logic [6:0]  code_length;
  } in_item_t;

  typedef struct packed {
    logic [7:0] packed_byte;
    logic       last_byte;
  } out_item_t;

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_EMIT,
    BK_FLUSH
  } bk_state_t;

endpackage

/* sv/lbp_front.sv */
// Front end: accepts items, clamps and masks write codes, drops empty writes.
`timescale 1ns / 1ps
module lbp_front #(
  parameter int MAX_CODE_BITS = 64
) (
  input  lbp_pkg::in_item_t in_data,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic              q_full,
  output logic              q_push,
  output logic [MAX_CODE_BITS + $clog2(MAX_CODE_BITS + 1):0] q_data
);

  localparam int LW = $clog2(MAX_CODE_BITS + 1);

  logic                     is_flush;
  logic [LW-1:0]            len_c;
  logic [MAX_CODE_BITS-1:0] mask;
  logic [MAX_CODE_BITS-1:0] value_m;
  logic                     keep;

  always_comb begin
    is_flush = (in_data.mode == lbp_pkg::MODE_FLUSH);
    if (in_data.code_length > 7'(MAX_CODE_BITS)) begin
      len_c = LW'(MAX_CODE_BITS);
    end else begin
      len_c = LW'(in_data.code_length);
    end
    // all ones when len_c == MAX_CODE_BITS (shift past width gives zero)
    mask    = ~({MAX_CODE_BITS{1'b1}} << len_c);
    value_m = in_data.code_value[MAX_CODE_BITS-1:0] & mask;
    keep    = is_flush || (len_c != '0);
  end

  assign in_stall = q_full;
  assign q_push   = in_valid && !q_full && keep;
  assign q_data   = {is_flush, value_m, len_c};

endmodule

/* sv/lbp_queue.sv */
// Short command queue between the front and back ends.
`timescale 1ns / 1ps
module lbp_queue #(
  parameter int WIDTH = 72
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  logic [WIDTH-1:0] push_data,
  input  logic             pop,
  output logic [WIDTH-1:0] head_data,
  output logic             full,
  output logic             empty
);

  localparam int PW = $clog2(lbp_pkg::QUEUE_DEPTH);
  localparam int CW = $clog2(lbp_pkg::QUEUE_DEPTH + 1);

  logic [WIDTH-1:0] mem [lbp_pkg::QUEUE_DEPTH];
  logic [PW-1:0]    wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0]    rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0]    count_r, count_nxt;
  logic             do_push, do_pop;

  assign full      = (count_r == CW'(lbp_pkg::QUEUE_DEPTH));
  assign empty     = (count_r == '0);
  assign head_data = mem[rd_ptr_r];
  assign do_push   = push && !full;
  assign do_pop    = pop && !empty;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PW'(lbp_pkg::QUEUE_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PW'(lbp_pkg::QUEUE_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr_r] <= push_data;
    end
  end

endmodule

/* sv/lbp_back.sv */
// Back end: merges codes into the partial byte and emits bytes one per cycle while the output is not stalled.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module lbp_back #(
  parameter int MAX_CODE_BITS = 64
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               q_empty,
  input  logic [MAX_CODE_BITS + $clog2(MAX_CODE_BITS + 1):0] q_data,
  output logic               q_pop,
  output logic               out_valid,
  input  logic               out_stall,
  output lbp_pkg::out_item_t out_data
);

  localparam int LW    = $clog2(MAX_CODE_BITS + 1);
  localparam int ENT_W = 1 + MAX_CODE_BITS + LW;

  lbp_pkg::bk_state_t       state_r, state_nxt;
  logic [7:0]               partial_r, partial_nxt;
  lbp_pkg::held_t           held_r, held_nxt;
  logic [MAX_CODE_BITS-1:0] value_r, value_nxt;
  logic [LW-1:0]            rem_r, rem_nxt;
  logic                     out_valid_r;
  lbp_pkg::out_item_t       out_data_r;

  logic                     e_flush;
  logic [MAX_CODE_BITS-1:0] e_value;
  logic [LW-1:0]            e_len;
  logic [LW-1:0]            room;
  logic [LW-1:0]            take;
  logic [LW-1:0]            step;
  logic                     out_free;
  logic                     load_out;
  logic                     out_last;

  assign e_flush  = q_data[ENT_W-1];
  assign e_value  = q_data[LW +: MAX_CODE_BITS];
  assign e_len    = q_data[LW-1:0];
  assign out_free = !out_valid_r || !out_stall;

  // bits that still fit in the partial byte, and bits moved per emitted byte
  assign room = LW'(lbp_pkg::held_t'(lbp_pkg::BYTE_BITS) - held_r);
  assign take = (e_len < room) ? e_len : room;
  assign step = (rem_r < LW'(lbp_pkg::BYTE_BITS)) ? rem_r : LW'(lbp_pkg::BYTE_BITS);

  always_comb begin
    state_nxt   = state_r;
    partial_nxt = partial_r;
    held_nxt    = held_r;
    value_nxt   = value_r;
    rem_nxt     = rem_r;
    q_pop       = 1'b0;
    load_out    = 1'b0;
    out_last    = 1'b0;
    case (state_r)
      lbp_pkg::BK_IDLE: begin
        if (!q_empty) begin
          q_pop = 1'b1;
          if (e_flush) begin
            if (held_r != '0) begin
              state_nxt = lbp_pkg::BK_FLUSH;
            end
          end else begin
            partial_nxt = partial_r | 8'(e_value[7:0] << held_r);
            held_nxt    = held_r + lbp_pkg::held_t'(take);
            value_nxt   = e_value >> take;
            rem_nxt     = e_len - take;
            if (e_len != take) begin
              state_nxt = lbp_pkg::BK_EMIT;
            end
          end
        end
      end
      lbp_pkg::BK_EMIT: begin
        if (out_free) begin
          load_out    = 1'b1;
          out_last    = (rem_r == step);
          partial_nxt = value_r[7:0];
          held_nxt    = lbp_pkg::held_t'(step);
          value_nxt   = value_r >> lbp_pkg::BYTE_BITS;
          rem_nxt     = rem_r - step;
          if (rem_r == step) begin
            state_nxt = lbp_pkg::BK_IDLE;
          end
        end
      end
      lbp_pkg::BK_FLUSH: begin
        if (out_free) begin
          load_out    = 1'b1;
          out_last    = 1'b1;
          partial_nxt = '0;
          held_nxt    = '0;
          state_nxt   = lbp_pkg::BK_IDLE;
        end
      end
      default: begin
        state_nxt = lbp_pkg::BK_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= lbp_pkg::BK_IDLE;
      partial_r   <= '0;
      held_r      <= '0;
      rem_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      partial_r <= partial_nxt;
      held_r    <= held_nxt;
      rem_r     <= rem_nxt;
      if (load_out) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    value_r <= value_nxt;
    if (load_out) begin
      out_data_r.packed_byte <= partial_r;
      out_data_r.last_byte   <= out_last;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  `LBP_ASSERT(a_emit_full, clk, rst_n, (state_r == lbp_pkg::BK_EMIT) |-> (held_r == lbp_pkg::held_t'(lbp_pkg::BYTE_BITS)))
  `LBP_ASSERT(a_idle_no_rem, clk, rst_n, (state_r == lbp_pkg::BK_IDLE) |-> (rem_r == '0))
  `LBP_ASSERT(a_flush_done, clk, rst_n, (state_r == lbp_pkg::BK_FLUSH && out_free) |=> (held_r == '0 && out_valid_r && out_data_r.last_byte))

endmodule

/* sv/lsb_first_bit_packer.sv */
// Top level of the LSB-first bit packer.
//
// Input channel (in_valid / in_stall / in_data): mode 0 appends the low
// code_length bits of code_value (clamped to MAX_CODE_BITS), bit 0 first;
// mode 1 flushes the pending partial byte, zero padded in its high bits.
// Output channel (out_valid / out_stall / out_data): one packed byte per
// item, last_byte marks the final byte caused by one input item.
// A full byte is held back until the next bit or a flush arrives.
// An accepted item passes through the queue and the back end's merge
// before its bytes reach the output register. Throughput: the back end
// then emits one byte per cycle while the output is not stalled, and pops
// the next item only after the last; a 64-bit code that starts on a full
// byte emits 8 bytes. Zero-length writes are dropped at the front and cost
// nothing. The 2-entry queue lets the front keep accepting while the back
// end is emitting or the receiver stalls. An output stall holds a valid
// output byte and stops emission; in_stall then rises once the queue fills.
// Reset (rst_n low, synchronous) empties the queue and the output register
// and clears the partial byte and its bit count.
`timescale 1ns / 1ps
module lsb_first_bit_packer #(
  parameter int MAX_CODE_BITS = 64
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  lbp_pkg::in_item_t  in_data,
  output logic               out_valid,
  input  logic               out_stall,
  output lbp_pkg::out_item_t out_data
);

  // queue entry: {flush flag, masked code bits, clamped length}
  localparam int LW    = $clog2(MAX_CODE_BITS + 1);
  localparam int ENT_W = 1 + MAX_CODE_BITS + LW;

  logic             q_push;
  logic             q_pop;
  logic             q_full;
  logic             q_empty;
  logic [ENT_W-1:0] q_wdata;
  logic [ENT_W-1:0] q_rdata;

  lbp_front #(
    .MAX_CODE_BITS(MAX_CODE_BITS)
  ) u_front (
    .in_data (in_data),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .q_full  (q_full),
    .q_push  (q_push),
    .q_data  (q_wdata)
  );

  lbp_queue #(
    .WIDTH(ENT_W)
  ) u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (q_push),
    .push_data(q_wdata),
    .pop      (q_pop),
    .head_data(q_rdata),
    .full     (q_full),
    .empty    (q_empty)
  );

  lbp_back #(
    .MAX_CODE_BITS(MAX_CODE_BITS)
  ) u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .q_empty  (q_empty),
    .q_data   (q_rdata),
    .q_pop    (q_pop),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data (out_data)
  );

endmodule

/* tb/lbp_checker.sv */
// Checker for the bit packer: predicts the packed bytes and compares them on the output.
`timescale 1ns / 1ps
module lbp_checker #(
  parameter int MAX_CODE_BITS = 64
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  input  logic               in_stall,
  input  lbp_pkg::in_item_t  in_data,
  input  logic               out_valid,
  input  logic               out_stall,
  input  lbp_pkg::out_item_t out_data,
  output int                 fail_count,
  output int                 pending
);

  // predicted packer state
  logic [7:0]      partial_byte;
  lbp_pkg::held_t  bits_held;

  lbp_pkg::out_item_t byte_queue[$];

  initial fail_count = 0;
  assign pending = byte_queue.size();

  // Append the bytes that one input item produces.
  function automatic void pack_code(input lbp_pkg::in_item_t it);
    lbp_pkg::out_item_t burst[8];
    int                 cnt;
    int unsigned        n;
    cnt = 0;
    if (it.mode == lbp_pkg::MODE_FLUSH) begin
      if (bits_held != 0) begin
        burst[cnt] = '{packed_byte: partial_byte, last_byte: 1'b0};
        cnt++;
        partial_byte = '0;
        bits_held    = '0;
      end
    end else begin
      n = (it.code_length > MAX_CODE_BITS) ? MAX_CODE_BITS : it.code_length;
      for (int unsigned i = 0; i < n; i++) begin
        // a full byte only leaves when the next bit shows up
        if (bits_held == lbp_pkg::BYTE_BITS) begin
          burst[cnt] = '{packed_byte: partial_byte, last_byte: 1'b0};
          cnt++;
          partial_byte = '0;
          bits_held    = '0;
        end
        partial_byte[bits_held[2:0]] = it.code_value[i];
        bits_held = bits_held + 1'b1;
      end
    end
    if (cnt > 0) burst[cnt-1].last_byte = 1'b1;
    for (int k = 0; k < cnt; k++) byte_queue.push_back(burst[k]);
  endfunction

  always @(posedge clk) begin
    lbp_pkg::out_item_t want;
    if (!rst_n) begin
      partial_byte = '0;
      bits_held    = '0;
      byte_queue.delete();
    end else begin
      if (in_valid && !in_stall) pack_code(in_data);
      if (out_valid && !out_stall) begin
        if (byte_queue.size() == 0) begin
          $error("unexpected item: packed_byte %0h last_byte %0b",
                 out_data.packed_byte, out_data.last_byte);
          fail_count++;
        end else begin
          want = byte_queue.pop_front();
          if (out_data.packed_byte !== want.packed_byte) begin
            $error("packed_byte: expected %0h, actual %0h",
                   want.packed_byte, out_data.packed_byte);
            fail_count++;
          end
          if (out_data.last_byte !== want.last_byte) begin
            $error("last_byte: expected %0b, actual %0b",
                   want.last_byte, out_data.last_byte);
            fail_count++;
          end
        end
      end
    end
  end

endmodule

/* tb/tb.sv */
// Testbench top for the bit packer: clock, reset, stimulus, receiver and verdict.
`timescale 1ns / 1ps
module tb;

  // Run limit in cycles. Slowest correct run is roughly 375 items x 8 bytes
  // with the receiver stalling 79% of cycles plus sender gaps; this is
  // several times that.
  localparam int CYCLE_LIMIT = 400000;
  localparam int HOLD_CYCLES = 300;   // long receiver hold-off

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               in_valid = 1'b0;
  logic               in_stall;
  lbp_pkg::in_item_t  in_data = '0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  lbp_pkg::out_item_t out_data;

  int fail_count;
  int pending;

  // idle knobs, percent of cycles
  int send_idle_pct = 0;
  int recv_stall_pct = 0;

  // hold-off requests: the receiver process owns the countdown
  int hold_seq = 0;

  always #5 clk = ~clk;

  lsb_first_bit_packer dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  lbp_checker chk (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_data    (in_data),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_data   (out_data),
    .fail_count (fail_count),
    .pending    (pending)
  );

  // Receiver: random stalls, or a solid hold-off when one is requested.
  // One nonblocking write to out_stall per edge.
  always @(posedge clk) begin
    static int hold_left = 0;
    static int seen_seq = 0;
    if (hold_seq != seen_seq) begin
      seen_seq  = hold_seq;
      hold_left = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      out_stall <= 1'b1;
      hold_left--;
    end else begin
      out_stall <= ($urandom_range(99) < recv_stall_pct);
    end
  end

  // Watchdog: a hung run or a lost byte ends here.
  initial begin
    repeat (CYCLE_LIMIT) @(posedge clk);
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  function automatic lbp_pkg::in_item_t mk(input logic md, input logic [63:0] val,
                                           input logic [6:0] len);
    lbp_pkg::in_item_t it;
    it.mode        = md;
    it.code_value  = val;
    it.code_length = len;
    return it;
  endfunction

  // Random item: mostly writes of 1..64 bits, some flushes, some zero-length,
  // some over-long lengths that the block clamps.
  function automatic lbp_pkg::in_item_t rand_item();
    lbp_pkg::in_item_t it;
    int                r;
    it.code_value = {$urandom, $urandom};
    it.mode       = ($urandom_range(99) < 12) ? lbp_pkg::MODE_FLUSH : lbp_pkg::MODE_WRITE;
    r = $urandom_range(99);
    if (r < 8)
      it.code_length = 7'($urandom_range(127, 65));
    else if (r < 13)
      it.code_length = 7'd0;
    else if (r < 25)
      it.code_length = 7'd64;
    else
      it.code_length = 7'($urandom_range(64, 1));
    return it;
  endfunction

  // Offer one item, with random idle cycles first, and wait for acceptance.
  // Entered and left at a rising edge, so in_valid gets one write per step.
  task automatic send(input lbp_pkg::in_item_t it);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= it;
    do @(posedge clk); while (in_stall);
  endtask

  task automatic send_random(input int n);
    repeat (n) send(rand_item());
  endtask

  initial begin
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // ---- directed part ----
    // flush straight out of reset: nothing pending, nothing comes out
    send(mk(lbp_pkg::MODE_FLUSH, 64'hFFFF_FFFF_FFFF_FFFF, 7'd64));
    // zero-length write with a busy value: no effect
    send(mk(lbp_pkg::MODE_WRITE, 64'hFFFF_FFFF_FFFF_FFFF, 7'd0));
    // single bits, then flush the padded byte
    send(mk(lbp_pkg::MODE_WRITE, 64'h1, 7'd1));
    send(mk(lbp_pkg::MODE_WRITE, 64'h0, 7'd1));
    send(mk(lbp_pkg::MODE_WRITE, 64'h5, 7'd3));
    send(mk(lbp_pkg::MODE_FLUSH, 64'h0, 7'd0));
    // exactly one byte: stays held until the flush
    send(mk(lbp_pkg::MODE_WRITE, 64'hA5, 7'd8));
    send(mk(lbp_pkg::MODE_FLUSH, 64'h1234_5678_9ABC_DEF0, 7'd127));
    // second flush finds nothing
    send(mk(lbp_pkg::MODE_FLUSH, 64'h0, 7'd0));
    // 64 ones from empty: seven bytes out, the eighth held
    send(mk(lbp_pkg::MODE_WRITE, 64'hFFFF_FFFF_FFFF_FFFF, 7'd64));
    // 64 bits on a full byte: eight bytes out
    send(mk(lbp_pkg::MODE_WRITE, 64'hAAAA_AAAA_AAAA_AAAA, 7'd64));
    send(mk(lbp_pkg::MODE_WRITE, 64'h5555_5555_5555_5555, 7'd64));
    // top bit only: checks the bit select above bit 31
    send(mk(lbp_pkg::MODE_WRITE, 64'h8000_0000_0000_0000, 7'd64));
    send(mk(lbp_pkg::MODE_WRITE, 64'h0000_0001_0000_0000, 7'd33));
    // lengths past the limit are clamped to 64
    send(mk(lbp_pkg::MODE_WRITE, 64'hDEAD_BEEF_CAFE_F00D, 7'd127));
    send(mk(lbp_pkg::MODE_WRITE, 64'h0123_4567_89AB_CDEF, 7'd65));
    // odd alignment, then a long code across it
    send(mk(lbp_pkg::MODE_WRITE, 64'h7F, 7'd7));
    send(mk(lbp_pkg::MODE_WRITE, 64'hF0F0_F0F0_F0F0_F0F0, 7'd63));
    send(mk(lbp_pkg::MODE_FLUSH, 64'hFFFF_FFFF_FFFF_FFFF, 7'd0));
    send(mk(lbp_pkg::MODE_WRITE, 64'h0, 7'd64));
    send(mk(lbp_pkg::MODE_FLUSH, 64'h0, 7'd64));

    // ---- random part, idle phases ----
    send_idle_pct = 0;  recv_stall_pct = 0;
    send_random(80);
    send_idle_pct = 79; recv_stall_pct = 0;
    send_random(80);
    send_idle_pct = 0;  recv_stall_pct = 79;
    send_random(80);
    send_idle_pct = 28; recv_stall_pct = 28;
    send_random(80);

    // back pressure: receiver holds off while the sender keeps offering,
    // so the queue fills and in_stall rises
    send_idle_pct = 0;  recv_stall_pct = 0;
    hold_seq++;
    repeat (12) send(mk(lbp_pkg::MODE_WRITE, {$urandom, $urandom}, 7'd64));
    send_random(18);

    in_valid <= 1'b0;

    // drain, then let the pipeline settle
    while (pending != 0) @(posedge clk);
    repeat (20) @(posedge clk);

    if (fail_count == 0 && pending == 0)
      $display("SCOREBOARD CLEAN");
    else
      $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
